@@ sv/qrr_pkg.sv @@
// Package for the quadratic real roots core: default sizes and status codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package qrr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_TWO_ROOTS = 2'd0,
    ST_A_ZERO    = 2'd1,
    ST_NO_ROOTS  = 2'd2
  } status_t;

endpackage

@@ sv/qrr_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on qrr_pkg only through the common style; all sizes are parameters.
`timescale 1ns / 1ps

module qrr_sqrt_pipe #(
  parameter int VW    = 65,
  parameter int RW    = 33,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [VW-1:0]    in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [RW-1:0]    out_root,
  output logic [TAG_W-1:0] out_tag
);
  import qrr_pkg::*;

  localparam int TW = 2 * RW + 1;

  logic             vld_r  [RW];
  logic [VW-1:0]    rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic [TAG_W-1:0] tag_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int BIT = RW - 1 - k;
    logic             vld_p;
    logic [VW-1:0]    rem_p;
    logic [RW-1:0]    root_p;
    logic [TAG_W-1:0] tag_p;
    logic [TW-1:0]    trial;
    logic             ge;
    logic [VW-1:0]    rem_nxt;
    logic [RW-1:0]    root_nxt;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = in_val;
      assign root_p = '0;
      assign tag_p  = in_tag;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign tag_p  = tag_r[k-1];
    end

    assign trial    = (TW'(root_p) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    assign ge       = TW'(rem_p) >= trial;
    assign rem_nxt  = ge ? rem_p - trial[VW-1:0] : rem_p;
    assign root_nxt = ge ? root_p | (RW'(1) << BIT) : root_p;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        tag_r[k]  <= tag_p;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_tag  = tag_r[RW-1];

endmodule

@@ sv/qrr_div_pipe.sv @@
// Dual-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on qrr_pkg only through the common style; all sizes are parameters.
`timescale 1ns / 1ps

module qrr_div_pipe #(
  parameter int NW    = 50,
  parameter int DW    = 34,
  parameter int TAG_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [TAG_W-1:0] in_tag,
  input  logic [NW-1:0]    num0,
  input  logic [DW-1:0]    den0,
  input  logic [NW-1:0]    num1,
  input  logic [DW-1:0]    den1,
  output logic             out_vld,
  output logic [TAG_W-1:0] out_tag,
  output logic [NW-1:0]    quo0,
  output logic [NW-1:0]    quo1
);
  import qrr_pkg::*;

  logic             vld_r  [NW];
  logic [TAG_W-1:0] tag_r  [NW];
  logic [NW-1:0]    num_r  [NW][2];
  logic [DW-1:0]    den_r  [NW][2];
  logic [DW-1:0]    rem_r  [NW][2];
  logic [NW-1:0]    quo_r  [NW][2];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam int BIT = NW - 1 - k;
    logic             vld_p;
    logic [TAG_W-1:0] tag_p;

    if (k == 0) begin : g_first
      assign vld_p = in_vld;
      assign tag_p = in_tag;
    end else begin : g_next
      assign vld_p = vld_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
      if (en) begin
        tag_r[k] <= tag_p;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NW-1:0] num_p;
      logic [DW-1:0] den_p;
      logic [DW-1:0] rem_p;
      logic [NW-1:0] quo_p;
      logic [DW:0]   rem_sh;
      logic          ge;
      logic [DW:0]   rem_sub;

      if (k == 0) begin : g_first
        assign num_p = (l == 0) ? num0 : num1;
        assign den_p = (l == 0) ? den0 : den1;
        assign rem_p = '0;
        assign quo_p = '0;
      end else begin : g_next
        assign num_p = num_r[k-1][l];
        assign den_p = den_r[k-1][l];
        assign rem_p = rem_r[k-1][l];
        assign quo_p = quo_r[k-1][l];
      end

      assign rem_sh  = {rem_p, num_p[BIT]};
      assign ge      = rem_sh >= {1'b0, den_p};
      assign rem_sub = ge ? rem_sh - {1'b0, den_p} : rem_sh;

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[k][l] <= num_p;
          den_r[k][l] <= den_p;
          rem_r[k][l] <= rem_sub[DW-1:0];
          quo_r[k][l] <= {quo_p[NW-2:0], ge};
        end
      end
    end
  end

  assign out_vld = vld_r[NW-1];
  assign out_tag = tag_r[NW-1];
  assign quo0    = quo_r[NW-1][0];
  assign quo1    = quo_r[NW-1][1];

endmodule

@@ sv/quadratic_real_roots_core.sv @@
// Top level of the quadratic real roots core: split, multiply, discriminant,
// square root, quotient and clamp stages. Uses qrr_pkg, qrr_sqrt_pipe, qrr_div_pipe.
//
// Usage:
//   Input channel in_valid/in_ready carries coef_a, coef_b, coef_c (signed fixed
//   point, WORD_BITS wide, FRAC_BITS fractional bits). One transfer in gives one
//   transfer out on out_valid/out_ready: status, root_first, root_second and
//   saturated. Roots are zero unless status is two distinct roots.
//   Throughput: one item per cycle while out_ready lets the pipe advance. The
//   one-bit-per-stage square root and the one-bit-per-stage dividers make up
//   most of the pipe.
//   The whole pipe advances together; in_ready is high whenever the output
//   register is empty or being taken, so a transfer in can land in the same
//   cycle a finished result waits, as long as the receiver takes it.
//   When the receiver holds out_ready low with a result waiting, every stage
//   holds and in_ready drops; nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; payload is not reset.
`timescale 1ns / 1ps

module quadratic_real_roots_core #(
  parameter int FRAC_BITS = qrr_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = qrr_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] in_coef_a,
  input  logic signed [WORD_BITS-1:0] in_coef_b,
  input  logic signed [WORD_BITS-1:0] in_coef_c,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [qrr_pkg::STATUS_W-1:0] out_status,
  output logic signed [WORD_BITS-1:0] out_root_first,
  output logic signed [WORD_BITS-1:0] out_root_second,
  output logic                        out_saturated
);
  import qrr_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int VW    = 2 * W + 1;
  localparam int RW    = W + 1;
  localparam int QW    = W + 2;
  localparam int NW    = W + F + 2;
  localparam int STAG  = STATUS_W + 3 + 3 * W;
  localparam int DTAG  = STATUS_W + 3;

  logic en;
  logic out_vld_r;

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // split into sign and magnitude
  logic         s1_vld_r;
  logic         s1_na_r, s1_nb_r, s1_nc_r;
  logic [W-1:0] s1_ma_r, s1_mb_r, s1_mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
    if (en) begin
      s1_na_r <= in_coef_a[W-1];
      s1_nb_r <= in_coef_b[W-1];
      s1_nc_r <= in_coef_c[W-1];
      s1_ma_r <= in_coef_a[W-1] ? W'(-in_coef_a) : W'(in_coef_a);
      s1_mb_r <= in_coef_b[W-1] ? W'(-in_coef_b) : W'(in_coef_b);
      s1_mc_r <= in_coef_c[W-1] ? W'(-in_coef_c) : W'(in_coef_c);
    end
  end

  // products b*b and a*c
  logic           s2_vld_r;
  logic           s2_na_r, s2_nb_r, s2_nc_r;
  logic [W-1:0]   s2_ma_r, s2_mb_r, s2_mc_r;
  logic [2*W-1:0] s2_pbb_r, s2_pac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_na_r  <= s1_na_r;
      s2_nb_r  <= s1_nb_r;
      s2_nc_r  <= s1_nc_r;
      s2_ma_r  <= s1_ma_r;
      s2_mb_r  <= s1_mb_r;
      s2_mc_r  <= s1_mc_r;
      s2_pbb_r <= s1_mb_r * s1_mb_r;
      s2_pac_r <= s1_ma_r * s1_mc_r;
    end
  end

  // discriminant and early status
  logic [VW-1:0]       p_ext, m_ext;
  logic [VW-1:0]       d_nxt;
  status_t             st_nxt;

  assign p_ext = VW'(s2_pbb_r);
  assign m_ext = VW'(s2_pac_r) << 2;

  always_comb begin
    st_nxt = ST_TWO_ROOTS;
    d_nxt  = '0;
    if (s2_ma_r == '0) begin
      st_nxt = ST_A_ZERO;
    end else if (s2_mc_r != '0 && s2_na_r != s2_nc_r) begin
      d_nxt = p_ext + m_ext;
    end else if (p_ext <= m_ext) begin
      st_nxt = ST_NO_ROOTS;
    end else begin
      d_nxt = p_ext - m_ext;
    end
  end

  logic          s3_vld_r;
  logic [VW-1:0] s3_d_r;
  logic [STAG-1:0] s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      s3_d_r   <= d_nxt;
      s3_tag_r <= {st_nxt, s2_na_r, s2_nb_r, s2_nc_r, s2_ma_r, s2_mb_r, s2_mc_r};
    end
  end

  logic            sq_vld;
  logic [RW-1:0]   sq_root;
  logic [STAG-1:0] sq_tag;

  qrr_sqrt_pipe #(
    .VW    (VW),
    .RW    (RW),
    .TAG_W (STAG)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_val   (s3_d_r),
    .in_tag   (s3_tag_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // form q and the two divisions
  logic [STATUS_W-1:0] sq_st;
  logic                sq_na, sq_nb, sq_nc;
  logic [W-1:0]        sq_ma, sq_mb, sq_mc;
  logic [QW-1:0]       qmag;

  assign {sq_st, sq_na, sq_nb, sq_nc, sq_ma, sq_mb, sq_mc} = sq_tag;
  assign qmag = QW'(sq_mb) + QW'(sq_root);

  logic            s4_vld_r;
  logic [DTAG-1:0] s4_tag_r;
  logic [NW-1:0]   s4_num0_r, s4_num1_r;
  logic [QW-1:0]   s4_den0_r, s4_den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= sq_vld;
    end
    if (en) begin
      s4_tag_r  <= {sq_st, !sq_nb, sq_na, sq_nc};
      s4_num0_r <= NW'(qmag) << F;
      s4_den0_r <= QW'(sq_ma) << 1;
      s4_num1_r <= NW'(sq_mc) << (F + 1);
      s4_den1_r <= qmag;
    end
  end

  logic            dv_vld;
  logic [DTAG-1:0] dv_tag;
  logic [NW-1:0]   dv_v1, dv_v2;

  qrr_div_pipe #(
    .NW    (NW),
    .DW    (QW),
    .TAG_W (DTAG)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s4_vld_r),
    .in_tag  (s4_tag_r),
    .num0    (s4_num0_r),
    .den0    (s4_den0_r),
    .num1    (s4_num1_r),
    .den1    (s4_den1_r),
    .out_vld (dv_vld),
    .out_tag (dv_tag),
    .quo0    (dv_v1),
    .quo1    (dv_v2)
  );

  // clamp, sign and order the roots
  logic [STATUS_W-1:0] dv_st;
  logic                dv_qneg, dv_na, dv_nc;
  logic                n1, n2;
  logic [NW-1:0]       lim1, lim2;
  logic                sat1, sat2;
  logic [W-1:0]        mag1, mag2, r1, r2;
  logic [W-1:0]        first_nxt, second_nxt;
  logic                sat_nxt;

  assign {dv_st, dv_qneg, dv_na, dv_nc} = dv_tag;
  assign n1   = dv_qneg ^ dv_na;
  assign n2   = dv_qneg ^ dv_nc;
  assign lim1 = n1 ? (NW'(1) << (W - 1)) : (NW'(1) << (W - 1)) - NW'(1);
  assign lim2 = n2 ? (NW'(1) << (W - 1)) : (NW'(1) << (W - 1)) - NW'(1);
  assign sat1 = dv_v1 > lim1;
  assign sat2 = dv_v2 > lim2;
  assign mag1 = sat1 ? lim1[W-1:0] : dv_v1[W-1:0];
  assign mag2 = sat2 ? lim2[W-1:0] : dv_v2[W-1:0];
  assign r1   = n1 ? W'(-mag1) : mag1;
  assign r2   = n2 ? W'(-mag2) : mag2;

  always_comb begin
    first_nxt  = '0;
    second_nxt = '0;
    sat_nxt    = 1'b0;
    if (dv_st == ST_TWO_ROOTS) begin
      sat_nxt = sat1 || sat2;
      if (!dv_qneg) begin
        first_nxt  = r1;
        second_nxt = r2;
      end else begin
        first_nxt  = r2;
        second_nxt = r1;
      end
    end
  end

  logic [STATUS_W-1:0] out_st_r;
  logic [W-1:0]        out_first_r, out_second_r;
  logic                out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
    if (en) begin
      out_st_r     <= dv_st;
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
      out_sat_r    <= sat_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_st_r;
  assign out_root_first  = out_first_r;
  assign out_root_second = out_second_r;
  assign out_saturated   = out_sat_r;

endmodule

@@ bench/quadratic_real_roots_core_tb.sv @@
// Self-checking bench for quadratic_real_roots_core: directed and random coefficient
// sets, root prediction done here in wide integer arithmetic, random idling on both sides.
// Depends on qrr_pkg and quadratic_real_roots_core.
`timescale 1ns / 1ps

module quadratic_real_roots_core_tb;
  import qrr_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WB = WORD_BITS_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [WB-1:0] a;
    logic signed [WB-1:0] b;
    logic signed [WB-1:0] c;
  } coef_set_t;

  typedef struct {
    status_t              status;
    logic signed [WB-1:0] x1;
    logic signed [WB-1:0] x2;
    logic                 sat;
  } roots_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [WB-1:0] in_coef_a = '0;
  logic signed [WB-1:0] in_coef_b = '0;
  logic signed [WB-1:0] in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [WB-1:0] out_root_first;
  logic signed [WB-1:0] out_root_second;
  logic out_saturated;

  coef_set_t coef_queue[$];
  roots_t    expected_roots[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  quadratic_real_roots_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_root_first(out_root_first),
    .out_root_second(out_root_second), .out_saturated(out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WB-1:0] clamp_root(logic neg, logic [127:0] mag, ref logic sat);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (WB - 1)) : ((128'd1 << (WB - 1)) - 1);
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? -mag[WB-1:0] : mag[WB-1:0];
  endfunction

  function automatic roots_t solve_quadratic(coef_set_t cs);
    roots_t r;
    logic na, nb, nc, qneg;
    logic [127:0] ma, mb, mc, sq, mc4, disc, root, t, qmag, v1, v2;
    r = '{ST_TWO_ROOTS, '0, '0, 1'b0};
    na = cs.a[WB-1];
    nb = cs.b[WB-1];
    nc = cs.c[WB-1];
    ma = na ? 128'(-cs.a) & ((128'd1 << WB) - 1) : 128'(cs.a);
    mb = nb ? 128'(-cs.b) & ((128'd1 << WB) - 1) : 128'(cs.b);
    mc = nc ? 128'(-cs.c) & ((128'd1 << WB) - 1) : 128'(cs.c);
    if (ma == 0) begin
      r.status = ST_A_ZERO;
      return r;
    end
    sq = mb * mb;
    mc4 = (ma * mc) << 2;
    if (mc != 0 && na != nc) begin
      disc = sq + mc4;
    end else begin
      if (sq <= mc4) begin
        r.status = ST_NO_ROOTS;
        return r;
      end
      disc = sq - mc4;
    end
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      t = root | (128'd1 << i);
      if (t * t <= disc) root = t;
    end
    qmag = mb + root;
    qneg = !(nb && mb != 0);
    v1 = (qmag << FB) / (ma << 1);
    v2 = (mc << (FB + 1)) / qmag;
    if (!qneg) begin
      r.x1 = clamp_root(qneg != na, v1, r.sat);
      r.x2 = clamp_root(qneg != nc, v2, r.sat);
    end else begin
      r.x2 = clamp_root(qneg != na, v1, r.sat);
      r.x1 = clamp_root(qneg != nc, v2, r.sat);
    end
    return r;
  endfunction

  function automatic logic signed [WB-1:0] rand_coef(int mode);
    logic signed [WB-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      2: v = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: v = $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
    return v;
  endfunction

  task automatic add_set(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
                         logic signed [WB-1:0] c);
    coef_set_t cs;
    cs.a = a;
    cs.b = b;
    cs.c = c;
    coef_queue.push_back(cs);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s at %0t: got %0d expected %0d", field, $time, got, want);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (coef_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        coef_set_t cs;
        cs = coef_queue.pop_front();
        in_coef_a <= cs.a;
        in_coef_b <= cs.b;
        in_coef_c <= cs.c;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: check the outgoing transfer, then predict the incoming one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $display("unexpected result transfer at %0t", $time);
          mismatches++;
        end else begin
          roots_t e;
          e = expected_roots.pop_front();
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
          if (out_root_first !== e.x1) report_mismatch("root_first", out_root_first, e.x1);
          if (out_root_second !== e.x2)
            report_mismatch("root_second", out_root_second, e.x2);
          if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
        end
      end
      if (in_valid && in_ready) begin
        coef_set_t cs;
        cs.a = in_coef_a;
        cs.b = in_coef_b;
        cs.c = in_coef_c;
        expected_roots.push_back(solve_quadratic(cs));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("quadratic_real_roots_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_set(0, 32'sh0001_0000, 32'sh0001_0000);
    add_set(0, 0, 0);
    add_set(32'sh0001_0000, 0, 0);
    add_set(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
    add_set(1, 2, 1);
    add_set(32'sh0001_0000, 0, 32'sh0001_0000);
    add_set(32'sh0001_0000, 32'shfffd_0000, 32'sh0002_0000);
    add_set(32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000);
    add_set(32'shffff_0000, 32'sh0001_0000, 32'sh0002_0000);
    add_set(32'sh0001_0000, 0, 32'shfffc_0000);
    add_set(1, 32'sh7fff_ffff, 1);
    add_set(1, 32'sh8000_0000, 32'sh8000_0000);
    add_set(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    add_set(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    add_set(32'sh8000_0000, 0, 32'sh8000_0000);
    add_set(32'sh7fff_ffff, 1, 32'sh7fff_ffff);
    add_set(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    add_set(-1, 32'shffff_ffff, 1);
    add_set(1, 0, -1);
    add_set(32'sh8000_0000, 32'sh7fff_ffff, 0);
    add_set(32'sh7fff_ffff, 0, 32'sh7fff_ffff);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < 300; n++) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          add_set(0, rand_coef(0), rand_coef(0));
        end else if (mode <= 3) begin
          add_set(rand_coef(0), rand_coef(0), rand_coef(0));
        end else if (mode <= 7) begin
          add_set(rand_coef(1), rand_coef(2), rand_coef(1));
        end else begin
          add_set(rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)),
                  rand_coef($urandom_range(0, 3)));
        end
      end
      while (coef_queue.size() > 0 || in_valid || expected_roots.size() > 0)
        @(posedge clk);
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("quadratic_real_roots_core verification clean");
    end else begin
      $display("quadratic_real_roots_core verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/qrr_pkg.sv
sv/qrr_sqrt_pipe.sv
sv/qrr_div_pipe.sv
sv/quadratic_real_roots_core.sv
bench/quadratic_real_roots_core_tb.sv
